FILE: hdl/trsd_pkg.sv
// Shared types and constants for the TGA run-length stream decoder.
`default_nettype none

package trsd_pkg;

  // Result kinds carried on the result channel.
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // Error codes reported with an error result.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIGNATURE = 3'd1,
    ERR_GEOMETRY  = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_OVERRUN   = 3'd4
  } err_t;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_HEAD = 6'b000010,
    PH_PKT  = 6'b000100,
    PH_PIX  = 6'b001000,
    PH_DONE = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_t;

  // Header byte positions.
  localparam logic [4:0] HDR_SIG_LEN   = 5'd12;
  localparam logic [4:0] HDR_TYPE_IDX  = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH     = 5'd16;
  localparam logic [4:0] HDR_DESC      = 5'd17;

  // Image type codes and accepted depths.
  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'd10;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // Packet header: run flag in the top bit, run length biased by 127.
  localparam logic [7:0] RUN_BIAS = 8'd127;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        depth_is_32;
    err_t        error_code;
    logic        image_done;
  } result_t;

  // Handshake status between the pipeline stages.
  typedef struct packed {
    logic advance;  // Input register hands its beat to the parser.
    logic out_free; // Result register can take a new result.
  } stage_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/trsd_if.sv
// Channel interfaces: byte stream in, decoded results out.
`default_nettype none

interface trsd_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface trsd_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  repeat_res;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        depth_is_32;
  logic [2:0]  error_code;
  logic        image_done;

  modport source (output valid, output kind, output red, output green, output blue,
                  output alpha, output repeat_res, output image_width,
                  output image_height, output depth_is_32, output error_code,
                  output image_done, input ready);
  modport sink (input valid, input kind, input red, input green, input blue,
                input alpha, input repeat_res, input image_width,
                input image_height, input depth_is_32, input error_code,
                input image_done, output ready);
endinterface

`default_nettype wire

FILE: hdl/trsd_in_stage.sv
// Input register: captures one byte beat and holds it until the parser takes it.
`default_nettype none

module trsd_in_stage
  import trsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  trsd_stream_if.sink stream,
  input  logic        out_free,
  output stage_ctl_t  ctl,
  output logic        beat_valid,
  output in_beat_t    beat
);

  logic     held;
  logic     held_next;
  in_beat_t beat_reg;
  logic     in_fire;

  // The held beat moves on whenever the result register has room.
  assign ctl.advance  = held && out_free;
  assign ctl.out_free = out_free;
  assign stream.ready = !held || ctl.advance;
  assign in_fire      = stream.valid && stream.ready;

  always_comb begin
    held_next = held;
    if (in_fire) begin
      held_next = 1'b1;
    end else if (ctl.advance) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      beat_reg.data_byte  <= stream.data_byte;
      beat_reg.first_byte <= stream.first_byte;
      beat_reg.last_byte  <= stream.last_byte;
    end
  end

  assign beat_valid = held;
  assign beat       = beat_reg;

endmodule

`default_nettype wire

FILE: hdl/trsd_parser.sv
// Header and pixel parser: updates the parse state once per byte and forms its result.
`default_nettype none

module trsd_parser
  import trsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl,
  input  in_beat_t   beat,
  output logic       res_valid,
  output result_t    res
);

  logic        fire;
  phase_t      phase, phase_next, phase_cur;
  logic [4:0]  hdr_idx, hdr_idx_next, hdr_idx_cur;
  logic        compressed, compressed_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic        depth32, depth32_next;
  logic        depth_ok, depth_ok_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_run, packet_run_next;
  logic [1:0]  byte_idx, byte_idx_next;
  logic [7:0]  pix_b0, pix_b0_next;
  logic [7:0]  pix_b1, pix_b1_next;
  logic [7:0]  pix_b2, pix_b2_next;
  logic        active;
  logic [1:0]  last_pos;
  logic [31:0] pl_dec;
  logic [31:0] pl_run;
  logic [7:0]  pkt_dec;
  logic [31:0] area;
  logic [7:0]  d;

  assign fire = ctl.advance;
  assign d    = beat.data_byte;

  assign phase_cur   = beat.first_byte ? PH_HEAD : phase;
  assign hdr_idx_cur = beat.first_byte ? 5'd0 : hdr_idx;
  assign active      = beat.first_byte || (phase == PH_HEAD) || (phase == PH_PKT) ||
                       (phase == PH_PIX);

  assign last_pos = depth32 ? 2'd3 : 2'd2;
  assign pl_dec   = pixels_left - 32'd1;
  assign pl_run   = pixels_left - {24'd0, packet_left};
  assign pkt_dec  = packet_left - 8'd1;
  assign area     = width_reg * height_reg;

  // Next state and result for the byte now in the input register.
  always_comb begin
    phase_next       = phase;
    hdr_idx_next     = hdr_idx;
    compressed_next  = compressed;
    width_reg_next   = width_reg;
    height_reg_next  = height_reg;
    depth32_next     = depth32;
    depth_ok_next    = depth_ok;
    pixels_left_next = pixels_left;
    packet_left_next = packet_left;
    packet_run_next  = packet_run;
    byte_idx_next    = byte_idx;
    pix_b0_next      = pix_b0;
    pix_b1_next      = pix_b1;
    pix_b2_next      = pix_b2;
    res_valid        = 1'b0;
    res              = '0;

    // A first byte abandons whatever parse was running.
    if (beat.first_byte) begin
      phase_next       = PH_HEAD;
      hdr_idx_next     = '0;
      compressed_next  = 1'b0;
      width_reg_next   = '0;
      height_reg_next  = '0;
      depth32_next     = 1'b0;
      depth_ok_next    = 1'b0;
      pixels_left_next = '0;
      packet_left_next = '0;
      packet_run_next  = 1'b0;
      byte_idx_next    = '0;
      pix_b0_next      = '0;
      pix_b1_next      = '0;
      pix_b2_next      = '0;
    end

    if (active) begin
      unique case (phase_cur)
        PH_HEAD: begin
          hdr_idx_next = (hdr_idx_cur < HDR_DESC) ? hdr_idx_cur + 5'd1 : hdr_idx_cur;
          if (hdr_idx_cur < HDR_SIG_LEN) begin
            // Signature bytes: all zero except the image type.
            if (hdr_idx_cur == HDR_TYPE_IDX) begin
              if (d == TYPE_RAW) begin
                compressed_next = 1'b0;
              end else if (d == TYPE_RLE) begin
                compressed_next = 1'b1;
              end else begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_SIGNATURE;
                phase_next     = PH_ERR;
              end
            end else if (d != 8'd0) begin
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SIGNATURE;
              phase_next     = PH_ERR;
            end
          end else if (hdr_idx_cur == HDR_WIDTH_LO) begin
            width_reg_next = {8'd0, d};
          end else if (hdr_idx_cur == HDR_WIDTH_HI) begin
            width_reg_next = {d, width_reg[7:0]};
          end else if (hdr_idx_cur == HDR_HEIGHT_LO) begin
            height_reg_next = {8'd0, d};
          end else if (hdr_idx_cur == HDR_HEIGHT_HI) begin
            height_reg_next = {d, height_reg[7:0]};
          end else if (hdr_idx_cur == HDR_DEPTH) begin
            depth32_next  = (d == DEPTH_32);
            depth_ok_next = (d == DEPTH_24) || (d == DEPTH_32);
          end else begin
            // Descriptor byte: check the geometry and open the pixel data.
            res_valid = 1'b1;
            if ((width_reg == 16'd0) || (height_reg == 16'd0) || !depth_ok) begin
              res.kind       = KIND_ERROR;
              res.error_code = ERR_GEOMETRY;
              phase_next     = PH_ERR;
            end else begin
              res.kind         = KIND_HEADER;
              res.image_width  = width_reg;
              res.image_height = height_reg;
              res.depth_is_32  = depth32;
              pixels_left_next = area;
              packet_left_next = '0;
              packet_run_next  = 1'b0;
              byte_idx_next    = '0;
              pix_b0_next      = '0;
              pix_b1_next      = '0;
              pix_b2_next      = '0;
              phase_next       = compressed ? PH_PKT : PH_PIX;
            end
          end
        end

        PH_PKT: begin
          // Packet header: top bit marks a run.
          if (!d[7]) begin
            packet_left_next = d + 8'd1;
            packet_run_next  = 1'b0;
          end else begin
            packet_left_next = d - RUN_BIAS;
            packet_run_next  = 1'b1;
          end
          phase_next = PH_PIX;
        end

        PH_PIX: begin
          if (byte_idx < last_pos) begin
            // Collect the leading bytes of the pixel.
            unique case (byte_idx)
              2'd0:    pix_b0_next = d;
              2'd1:    pix_b1_next = d;
              default: pix_b2_next = d;
            endcase
            byte_idx_next = byte_idx + 2'd1;
          end else begin
            // Last byte of the pixel: emit the color.
            byte_idx_next = '0;
            pix_b0_next   = '0;
            pix_b1_next   = '0;
            pix_b2_next   = '0;
            res.kind      = KIND_PIXEL;
            res.blue      = pix_b0;
            res.green     = pix_b1;
            res.red       = depth32 ? pix_b2 : d;
            res.alpha     = depth32 ? d : 8'd0;
            res.repeat_res = 8'd1;
            res_valid     = 1'b1;
            if (!compressed) begin
              pixels_left_next = pl_dec;
              res.image_done   = (pl_dec == 32'd0);
              if (pl_dec == 32'd0) begin
                phase_next = PH_DONE;
              end
            end else if (packet_run) begin
              if ({24'd0, packet_left} > pixels_left) begin
                res            = '0;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_OVERRUN;
                phase_next     = PH_ERR;
              end else begin
                pixels_left_next = pl_run;
                res.repeat_res   = packet_left;
                res.image_done   = (pl_run == 32'd0);
                packet_left_next = '0;
                phase_next       = (pl_run == 32'd0) ? PH_DONE : PH_PKT;
              end
            end else begin
              if (pixels_left == 32'd0) begin
                res            = '0;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_OVERRUN;
                phase_next     = PH_ERR;
              end else begin
                pixels_left_next = pl_dec;
                packet_left_next = pkt_dec;
                // A literal packet may outlast the image; only its end completes it.
                if (pkt_dec == 8'd0) begin
                  res.image_done = (pl_dec == 32'd0);
                  phase_next     = (pl_dec == 32'd0) ? PH_DONE : PH_PKT;
                end
              end
            end
          end
        end

        default: begin
        end
      endcase

      // An early end replaces any pixel or header result, not an earlier error.
      if (beat.last_byte && (phase_next != PH_DONE) && (phase_next != PH_ERR)) begin
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_TRUNCATED;
        res_valid      = 1'b1;
        phase_next     = PH_ERR;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      hdr_idx     <= '0;
      compressed  <= 1'b0;
      depth32     <= 1'b0;
      depth_ok    <= 1'b0;
      pixels_left <= '0;
      packet_left <= '0;
      packet_run  <= 1'b0;
      byte_idx    <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      hdr_idx     <= hdr_idx_next;
      compressed  <= compressed_next;
      depth32     <= depth32_next;
      depth_ok    <= depth_ok_next;
      pixels_left <= pixels_left_next;
      packet_left <= packet_left_next;
      packet_run  <= packet_run_next;
      byte_idx    <= byte_idx_next;
    end
  end

  // Header values and partial pixel bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= '0;
      height_reg <= '0;
    end else if (fire) begin
      width_reg  <= width_reg_next;
      height_reg <= height_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pix_b0 <= pix_b0_next;
      pix_b1 <= pix_b1_next;
      pix_b2 <= pix_b2_next;
    end
  end

`ifndef SYNTHESIS
  // Outside a header the pixel budget only shrinks.
  a_budget_shrinks: assert property (@(posedge clk) disable iff (rst)
    (!rst && !(fire && beat.first_byte) && (phase != PH_HEAD)) |=>
      (pixels_left <= $past(pixels_left)))
    else $error("pixel count grew outside a header");

  // Any error result leaves the parser in the error phase.
  a_error_phase: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && (res.kind == KIND_ERROR)) |=> (phase == PH_ERR))
    else $error("error reported without entering error phase");

  // The completing pixel ends the image.
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.image_done) |=> (phase == PH_DONE))
    else $error("image completion without entering done phase");

  // Packet headers exist only in run-length images.
  a_pkt_compressed: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PKT) |-> compressed)
    else $error("packet phase in a raw image");

  // A 24-bit pixel never collects more than two leading bytes.
  a_byte_idx_range: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_PIX) && !depth32) |-> (byte_idx != 2'd3))
    else $error("pixel byte index out of range");
`endif

endmodule

`default_nettype wire

FILE: hdl/trsd_out_reg.sv
// Result register: holds one result beat until the consumer takes it.
`default_nettype none

module trsd_out_reg
  import trsd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  stage_ctl_t      ctl,
  input  logic            res_valid,
  input  result_t         res,
  output logic            out_free,
  trsd_result_if.source   result
);

  logic    full;
  logic    full_next;
  logic    load;
  result_t res_reg;

  assign out_free = !full || result.ready;
  assign load     = ctl.advance && res_valid;

  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (result.ready) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      res_reg <= res;
    end
  end

  assign result.valid        = full;
  assign result.kind         = res_reg.kind;
  assign result.red          = res_reg.red;
  assign result.green        = res_reg.green;
  assign result.blue         = res_reg.blue;
  assign result.alpha        = res_reg.alpha;
  assign result.repeat_res   = res_reg.repeat_res;
  assign result.image_width  = res_reg.image_width;
  assign result.image_height = res_reg.image_height;
  assign result.depth_is_32  = res_reg.depth_is_32;
  assign result.error_code   = res_reg.error_code;
  assign result.image_done   = res_reg.image_done;

endmodule

`default_nettype wire

FILE: hdl/tga_rle_stream_decoder.sv
// Top level of the TGA type 2 and type 10 stream decoder.
// Feed a TGA file one byte per beat, marking its first and final bytes. The
// decoder checks the 12-byte signature, reads width, height and depth, then
// decodes raw or run-length pixels and emits at most one result per byte: a
// header result after the descriptor byte, one result per decoded color with
// its repeat count (red and blue swapped back to RGB order), or an error.
// It takes one byte every cycle as long as the result side keeps up; while a
// result waits unaccepted at the output, the input register holds one more
// byte and then stalls the input. An accepted byte waits in the input
// register; its result is then registered in the result register. The rate is
// set by the parser state register, which every byte updates once. Bytes before
// the first marked byte, and after completion or an error, are dropped silently
// until the next first byte. No clearing pass follows reset.
`default_nettype none

module tga_rle_stream_decoder
  import trsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  trsd_stream_if.sink   stream,
  trsd_result_if.source result
);

  stage_ctl_t ctl;
  logic       out_free;
  logic       beat_valid;
  in_beat_t   beat;
  logic       res_valid;
  result_t    res;
  logic       parse_fire_ok;

  trsd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .out_free   (out_free),
    .ctl        (ctl),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  trsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  trsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .result    (result)
  );

  // The parser only steps on a held beat.
  assign parse_fire_ok = !ctl.advance || beat_valid;

`ifndef SYNTHESIS
  a_advance_held: assert property (@(posedge clk) disable iff (rst)
    parse_fire_ok)
    else $error("parser stepped without a held beat");

  a_result_done_pixel: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.image_done) |-> (result.kind == KIND_PIXEL))
    else $error("image completion flagged on a non-pixel result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !(ctl.advance && res_valid))
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: test/tga_rle_stream_decoder_tb.sv
// Self-checking testbench for the TGA type 2 and type 10 stream decoder.
`timescale 1ns / 1ps

module tga_rle_stream_decoder_tb;
  import trsd_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1650;
  localparam int unsigned IDLE_PCT     = 19;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // Tracks the decoder's parse state and the results it still owes.
  class tga_result_tracker;
    phase_t      phase;
    logic [4:0]  hdr_pos;
    bit          rle;
    logic [15:0] img_w;
    logic [15:0] img_h;
    bit          depth32;
    logic [31:0] pix_left;
    logic [7:0]  pkt_left;
    bit          pkt_run;
    logic [1:0]  byte_pos;
    logic [23:0] pix_acc;
    result_t     expected_results[$];
    int unsigned parsed_bytes;
    int unsigned mismatches;

    function new();
      phase = PH_IDLE;
      parsed_bytes = 0;
      mismatches = 0;
      restart_parse();
    endfunction

    function void restart_parse();
      hdr_pos = '0;
      rle = 1'b0;
      img_w = '0;
      img_h = '0;
      depth32 = 1'b0;
      pix_left = '0;
      pkt_left = '0;
      pkt_run = 1'b0;
      byte_pos = '0;
      pix_acc = '0;
    endfunction

    function result_t error_beat(err_t code);
      result_t r;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      return r;
    endfunction

    // Advances the parse by one byte; returns 1 when the byte yields a result.
    function bit decode_byte(in_beat_t b, output result_t r);
      logic [7:0] d;
      logic [4:0] pos;
      logic [1:0] final_pos;
      bit produced;
      d = b.data_byte;
      r = '0;
      produced = 1'b0;
      if (b.first_byte) begin
        phase = PH_HEAD;
        restart_parse();
      end else if (phase != PH_HEAD && phase != PH_PKT && phase != PH_PIX) begin
        return 1'b0;
      end
      parsed_bytes++;

      if (phase == PH_HEAD) begin
        pos = hdr_pos;
        if (pos < HDR_SIG_LEN) begin
          // Signature: all zero except the image type.
          if (pos == HDR_TYPE_IDX) begin
            if (d == TYPE_RAW) rle = 1'b0;
            else if (d == TYPE_RLE) rle = 1'b1;
            else begin
              r = error_beat(ERR_SIGNATURE);
              phase = PH_ERR;
              return 1'b1;
            end
          end else if (d != 8'h00) begin
            r = error_beat(ERR_SIGNATURE);
            phase = PH_ERR;
            return 1'b1;
          end
        end else if (pos == HDR_WIDTH_LO) begin
          img_w = {8'h00, d};
        end else if (pos == HDR_WIDTH_HI) begin
          img_w[15:8] = d;
        end else if (pos == HDR_HEIGHT_LO) begin
          img_h = {8'h00, d};
        end else if (pos == HDR_HEIGHT_HI) begin
          img_h[15:8] = d;
        end else if (pos == HDR_DEPTH) begin
          pix_acc = {16'h0000, d};
          depth32 = (d == DEPTH_32);
        end else begin
          // Descriptor byte closes the header; geometry is judged here.
          if (img_w == 0 || img_h == 0 || (pix_acc != DEPTH_24 && pix_acc != DEPTH_32)) begin
            r = error_beat(ERR_GEOMETRY);
            phase = PH_ERR;
            return 1'b1;
          end
          r.kind = KIND_HEADER;
          r.image_width = img_w;
          r.image_height = img_h;
          r.depth_is_32 = depth32;
          produced = 1'b1;
          pix_left = {16'h0000, img_w} * {16'h0000, img_h};
          pix_acc = '0;
          byte_pos = '0;
          pkt_left = '0;
          pkt_run = 1'b0;
          phase = rle ? PH_PKT : PH_PIX;
        end
        if (pos < HDR_DESC) hdr_pos = pos + 5'd1;
      end else if (phase == PH_PKT) begin
        // Packet header: top bit selects a run, otherwise a literal packet.
        if (!d[7]) begin
          pkt_left = d + 8'd1;
          pkt_run = 1'b0;
        end else begin
          pkt_left = d - RUN_BIAS;
          pkt_run = 1'b1;
        end
        phase = PH_PIX;
      end else begin
        final_pos = depth32 ? 2'd3 : 2'd2;
        if (byte_pos < final_pos) begin
          pix_acc = pix_acc | (24'(d) << (8 * byte_pos));
          byte_pos = byte_pos + 2'd1;
        end else begin
          // Pixel complete: file order is blue, green, red, alpha.
          r.kind = KIND_PIXEL;
          r.blue = pix_acc[7:0];
          r.green = pix_acc[15:8];
          r.red = depth32 ? pix_acc[23:16] : d;
          r.alpha = depth32 ? d : 8'h00;
          r.repeat_res = 8'd1;
          pix_acc = '0;
          byte_pos = '0;
          if (!rle) begin
            pix_left = pix_left - 32'd1;
            r.image_done = (pix_left == 0);
            if (pix_left == 0) phase = PH_DONE;
          end else if (pkt_run) begin
            if (pkt_left > pix_left) begin
              r = error_beat(ERR_OVERRUN);
              phase = PH_ERR;
              return 1'b1;
            end
            pix_left = pix_left - pkt_left;
            r.repeat_res = pkt_left;
            r.image_done = (pix_left == 0);
            pkt_left = '0;
            phase = (pix_left == 0) ? PH_DONE : PH_PKT;
          end else begin
            // A literal packet may spill past the image; the spill is an overrun.
            if (pix_left == 0) begin
              r = error_beat(ERR_OVERRUN);
              phase = PH_ERR;
              return 1'b1;
            end
            pix_left = pix_left - 32'd1;
            pkt_left = pkt_left - 8'd1;
            if (pkt_left == 0) begin
              r.image_done = (pix_left == 0);
              phase = (pix_left == 0) ? PH_DONE : PH_PKT;
            end
          end
          produced = 1'b1;
        end
      end

      // An early end replaces this byte's own pixel or header result.
      if (b.last_byte && phase != PH_DONE && phase != PH_ERR) begin
        r = error_beat(ERR_TRUNCATED);
        phase = PH_ERR;
        produced = 1'b1;
      end
      return produced;
    endfunction

    function void note_byte(in_beat_t b);
      result_t r;
      if (decode_byte(b, r)) expected_results.push_back(r);
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with none expected: kind %0h", got.kind);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("repeat_res", want.repeat_res, got.repeat_res);
      compare_field("image_width", want.image_width, got.image_width);
      compare_field("image_height", want.image_height, got.image_height);
      compare_field("depth_is_32", want.depth_is_32, got.depth_is_32);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("image_done", want.image_done, got.image_done);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit calm;
  int unsigned hold_requests;
  tga_result_tracker tracker;

  trsd_stream_if byte_ch();
  trsd_result_if res_ch();

  tga_rle_stream_decoder u_top (
    .clk(clk),
    .rst(rst),
    .stream(byte_ch),
    .result(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one byte, idling at random first, and records it once accepted.
  task automatic send_beat(logic [7:0] d, bit is_first, bit is_last);
    in_beat_t b;
    b.data_byte = d;
    b.first_byte = is_first;
    b.last_byte = is_last;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= d;
    byte_ch.first_byte <= is_first;
    byte_ch.last_byte <= is_last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    tracker.note_byte(b);
  endtask

  task automatic send_file(ref logic [7:0] fb[$], input bit mark_last);
    for (int i = 0; i < fb.size(); i++) begin
      send_beat(fb[i], i == 0, mark_last && i == fb.size() - 1);
    end
  endtask

  // Stops offering bytes until every owed result has come back.
  task automatic wait_for_results();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Builds one file: mostly well formed, some with a deliberate flaw.
  function automatic void make_tga_file(ref logic [7:0] fb[$], output bit mark_last);
    bit rle;
    bit as_run;
    int unsigned flaw, w, h, bpp, cap, left, cnt, max_len, keep;
    longint unsigned total;
    logic [7:0] depth;
    fb.delete();
    rle = 1'($urandom_range(1));
    flaw = $urandom_range(99);
    if (rle && $urandom_range(7) == 0) begin
      w = $urandom_range(300, 100);
      h = $urandom_range(2, 1);
    end else begin
      w = $urandom_range(8, 1);
      h = $urandom_range(4, 1);
    end
    if (flaw < 4) begin
      if ($urandom_range(1)) w = 0;
      else h = 0;
    end else if (flaw < 8) begin
      w = $urandom_range(65535);
      h = $urandom_range(65535);
    end
    depth = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
    if (flaw >= 8 && flaw < 12) depth = 8'($urandom_range(255));
    bpp = (depth == DEPTH_32) ? 4 : 3;

    // Header, sometimes with one signature byte corrupted.
    fb.push_back(8'h00);
    fb.push_back(8'h00);
    fb.push_back(rle ? TYPE_RLE : TYPE_RAW);
    repeat (9) fb.push_back(8'h00);
    if (flaw >= 12 && flaw < 18) fb[$urandom_range(11)] = 8'($urandom_range(255, 1));
    fb.push_back(w[7:0]);
    fb.push_back(w[15:8]);
    fb.push_back(h[7:0]);
    fb.push_back(h[15:8]);
    fb.push_back(depth);
    fb.push_back(8'($urandom_range(255)));

    // Pixel data; huge images are only started, never finished.
    total = longint'(w) * h;
    cap = rle ? 400 : 48;
    if (flaw >= 4 && flaw < 8) cap = 12;
    left = (total < cap) ? 32'(total) : cap;
    while (left > 0) begin
      if (!rle) begin
        cnt = 1;
        repeat (bpp) fb.push_back(8'($urandom_range(255)));
      end else begin
        as_run = 1'($urandom_range(1));
        max_len = (as_run || $urandom_range(15) == 0) ? 128 : 6;
        cnt = $urandom_range((left < max_len) ? left : max_len, 1);
        if (flaw >= 18 && flaw < 26 && left < max_len && $urandom_range(3) == 0)
          cnt = $urandom_range(max_len, left + 1);
        if (as_run) begin
          fb.push_back(8'(RUN_BIAS + cnt));
          repeat (bpp) fb.push_back(8'($urandom_range(255)));
        end else begin
          fb.push_back(8'(cnt - 1));
          repeat (cnt * bpp) fb.push_back(8'($urandom_range(255)));
        end
      end
      left = (cnt >= left) ? 0 : left - cnt;
    end

    // Early end, or junk after the image that the decoder must drop.
    mark_last = ($urandom_range(4) != 0);
    if (flaw >= 26 && flaw < 40) begin
      keep = $urandom_range(fb.size(), 1);
      while (fb.size() > keep) void'(fb.pop_back());
    end else if (flaw >= 40 && flaw < 46) begin
      repeat ($urandom_range(4, 1)) fb.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Result side: random stalls plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_served;
    result_t got;
    stall_left = 0;
    holds_served = 0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind = kind_t'(res_ch.kind);
        got.red = res_ch.red;
        got.green = res_ch.green;
        got.blue = res_ch.blue;
        got.alpha = res_ch.alpha;
        got.repeat_res = res_ch.repeat_res;
        got.image_width = res_ch.image_width;
        got.image_height = res_ch.image_height;
        got.depth_is_32 = res_ch.depth_is_32;
        got.error_code = err_t'(res_ch.error_code);
        got.image_done = res_ch.image_done;
        tracker.check_result(got);
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk);
    end
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[tga_rle_stream_decoder] ERROR");
    $finish;
  end

  // Byte side: directed files, then random files until enough bytes are parsed.
  initial begin : byte_source
    logic [7:0] fb[$];
    bit mark_last;
    int unsigned file_no;
    tracker = new();
    calm = 1'b0;
    hold_requests = 0;
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.first_byte <= 1'b0;
    byte_ch.last_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // A stray byte before any file start is dropped.
    send_beat(8'hFF, 1'b0, 1'b0);
    // A bad signature on a one-byte file wins over the early end.
    send_beat(8'h01, 1'b1, 1'b1);
    // A lone first byte that is also the last one ends inside the header.
    send_beat(8'h00, 1'b1, 1'b1);

    // Smallest image: 1x1 at 32 bits, one run of one pixel.
    fb.delete();
    repeat (2) fb.push_back(8'h00);
    fb.push_back(TYPE_RLE);
    repeat (9) fb.push_back(8'h00);
    fb.push_back(8'h01);
    fb.push_back(8'h00);
    fb.push_back(8'h01);
    fb.push_back(8'h00);
    fb.push_back(DEPTH_32);
    fb.push_back(8'h00);
    fb.push_back(8'h80);
    fb.push_back(8'h11);
    fb.push_back(8'h22);
    fb.push_back(8'h33);
    fb.push_back(8'h44);
    send_file(fb, 1'b1);
    wait_for_results();

    file_no = 0;
    while (tracker.parsed_bytes < ITEM_TARGET) begin
      calm = (file_no >= 12 && file_no < 18);
      if (file_no == 6) hold_requests++;
      if (file_no == 25) wait_for_results();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(3, 1))
          send_beat(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      end
      make_tga_file(fb, mark_last);
      send_file(fb, mark_last);
      file_no++;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("[tga_rle_stream_decoder] OK");
    end else begin
      $display("[tga_rle_stream_decoder] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/trsd_pkg.sv
hdl/trsd_if.sv
hdl/trsd_in_stage.sv
hdl/trsd_parser.sv
hdl/trsd_out_reg.sv
hdl/tga_rle_stream_decoder.sv
test/tga_rle_stream_decoder_tb.sv
